// ===== hw/rtl/lcgrr_pkg.sv =====
package lcgrr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W + 1);

  localparam logic [WORD_W-1:0] LCG_MUL  = 32'd1103515245;
  localparam logic [WORD_W-1:0] LCG_ADD  = 32'd12345;
  localparam logic [WORD_W-1:0] LCG_FOLD = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] SEED_RST = 32'd1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t remainder;
  } div_rsp_t;

  // one LCG step; an all-ones result folds to zero
  function automatic word_t lcg_advance(input word_t s);
    word_t x;
    x = word_t'(LCG_MUL * s + LCG_ADD);
    return (x == LCG_FOLD) ? '0 : x;
  endfunction

endpackage

// ===== hw/rtl/lcgrr_divider.sv =====
module lcgrr_divider (
  input  logic                clk,
  input  logic                rst,
  input  lcgrr_pkg::div_req_t req,
  output lcgrr_pkg::div_rsp_t rsp
);
  import lcgrr_pkg::*;

  word_t              rem;
  word_t              dq;
  word_t              dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [WORD_W:0]    trial;
  logic [WORD_W:0]    diff;

  // restoring divider, one quotient bit a cycle; only the remainder is kept
  assign trial = {rem, dq[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WORD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dq  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
      dq  <= {dq[WORD_W-2:0], 1'b0};
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ===== hw/rtl/lcg_ranged_random.sv =====
// Ranged LCG random source. Each request on s_axis carries an inclusive
// interval [floor, ceil]; the block steps its 32-bit seed once
// (x = 1103515245*seed + 12345 mod 2^32, all-ones folds to 0) and returns
// floor + seed mod (ceil - floor + 1), or floor + seed when that span wraps
// to zero, together with the new seed. One request is worked at a time: it
// passes ST_MUL, ST_DSTRT and ST_DWAIT, where the radix-2 divider retires
// one remainder bit per cycle (32 steps), to ST_FIN; a full-span request
// skips the divider, going from ST_DSTRT to ST_FIN. s_axis_tready is
// high only while the sequencer is idle; a finished result waits in the
// output register, so the next request can be taken while it is unread.
// A write on seed_wr_en loads the running seed; write it only when idle.
module lcg_ranged_random (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] floor_value, [63:32] ceil_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] random_value, [63:32] seed_out
);
  import lcgrr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DSTRT = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  word_t      seed;
  word_t      floor_val;
  word_t      span;
  word_t      offset;
  word_t      out_rand;
  word_t      out_seed;
  logic       out_valid;
  logic       out_free;
  div_req_t   dreq;
  div_rsp_t   drsp;

  lcgrr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign out_free       = !out_valid || m_axis_tready;
  assign dreq.start     = (state == ST_DSTRT) && (span != '0);
  assign dreq.dividend  = seed;
  assign dreq.divisor   = span;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_DSTRT;
      ST_DSTRT: state_next = (span == '0) ? ST_FIN : ST_DWAIT;
      ST_DWAIT: if (drsp.done) state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= SEED_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (seed_wr_en) begin
        seed <= seed_wr_data;
      end else if (state == ST_MUL) begin
        seed <= lcg_advance(seed);
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      floor_val <= s_axis_tdata[31:0];
      span      <= s_axis_tdata[63:32] - s_axis_tdata[31:0] + 32'd1;
    end
    if (state == ST_DSTRT) begin
      offset <= seed;   // full span: used as is
    end else if (state == ST_DWAIT && drsp.done) begin
      offset <= drsp.remainder;
    end
    if (state == ST_FIN && out_free) begin
      out_rand <= floor_val + offset;
      out_seed <= seed;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_seed, out_rand};

endmodule

// ===== hw/rtl/lcgrr_checker.sv =====
module lcgrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        seed_wr_en,
  input logic [31:0] seed_wr_data,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import lcgrr_pkg::*;

  word_t last_seed;
  logic  in_acc;
  logic  out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // tracks the seed the next result must step from
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seed <= SEED_RST;
    end else if (seed_wr_en) begin
      last_seed <= seed_wr_data;
    end else if (out_acc) begin
      last_seed <= m_axis_tdata[63:32];
    end
  end

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("not ready after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("request taken while busy");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_seed_chain: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> m_axis_tdata[63:32] == lcg_advance(last_seed))
    else $error("seed_out does not follow previous seed");

  a_in_words: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && !$past(s_axis_tready) |-> !$past(in_acc) || $past(rst))
    else $error("ready rose right after a request");

endmodule

bind lcg_ranged_random lcgrr_checker u_lcgrr_checker (
  .clk           (clk),
  .rst           (rst),
  .seed_wr_en    (seed_wr_en),
  .seed_wr_data  (seed_wr_data),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
